[rtl/fota_pkg.sv]
// shared types and constants for the flipped overlap trim adjust block
package fota_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int LANES  = 4;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[rtl/fota_if.sv]
// item channel interfaces for records in and adjusted results out
interface fota_in_if #(parameter int W = 24);
  logic         valid;
  logic         ready;
  logic [W-1:0] a_overlap_begin;
  logic [W-1:0] a_overlap_end;
  logic [W-1:0] b_overlap_first;
  logic [W-1:0] b_overlap_last;
  logic [W-1:0] a_clear_begin;
  logic [W-1:0] a_clear_end;
  logic [W-1:0] b_clear_begin;
  logic [W-1:0] b_clear_end;
  logic [W-1:0] b_read_length;

  modport source (output valid, a_overlap_begin, a_overlap_end, b_overlap_first,
                  b_overlap_last, a_clear_begin, a_clear_end, b_clear_begin,
                  b_clear_end, b_read_length, input ready);
  modport sink (input valid, a_overlap_begin, a_overlap_end, b_overlap_first,
                b_overlap_last, a_clear_begin, a_clear_end, b_clear_begin,
                b_clear_end, b_read_length, output ready);
endinterface

interface fota_out_if #(parameter int W = 24);
  logic         valid;
  logic         ready;
  logic         accepted;
  logic [W-1:0] a_adj_begin;
  logic [W-1:0] a_adj_end;
  logic [W-1:0] b_adj_begin;
  logic [W-1:0] b_adj_end;
  logic [W-1:0] a_clr_begin_out;
  logic [W-1:0] a_clr_end_out;
  logic [W-1:0] b_clr_begin_flip;
  logic [W-1:0] b_clr_end_flip;

  modport source (output valid, accepted, a_adj_begin, a_adj_end, b_adj_begin,
                  b_adj_end, a_clr_begin_out, a_clr_end_out, b_clr_begin_flip,
                  b_clr_end_flip, input ready);
  modport sink (input valid, accepted, a_adj_begin, a_adj_end, b_adj_begin,
                b_adj_end, a_clr_begin_out, a_clr_end_out, b_clr_begin_flip,
                b_clr_end_flip, output ready);
endinterface

[rtl/fota_front.sv]
// front end: mirrors b coordinates, classifies the record, finds lengths and trims
module fota_front #(
  parameter int W  = 24,
  parameter int RW = 1 + 14 * W
) (
  input  logic [W-1:0]  a_overlap_begin,
  input  logic [W-1:0]  a_overlap_end,
  input  logic [W-1:0]  b_overlap_first,
  input  logic [W-1:0]  b_overlap_last,
  input  logic [W-1:0]  a_clear_begin,
  input  logic [W-1:0]  a_clear_end,
  input  logic [W-1:0]  b_clear_begin,
  input  logic [W-1:0]  b_clear_end,
  input  logic [W-1:0]  b_read_length,
  output logic [RW-1:0] rec
);

  logic [W-1:0] ab, ae, bb, be, acb, ace, bcb, bce;
  logic [W-1:0] alen, blen, anb, bnb, ane, bne;
  logic         ok;

  always_comb begin
    ab  = a_overlap_begin;
    ae  = a_overlap_end;
    acb = a_clear_begin;
    ace = a_clear_end;
    // mirror onto reversed b, wrapping modulo the width
    bb  = b_read_length - b_overlap_first;
    be  = b_read_length - b_overlap_last;
    bcb = b_read_length - b_clear_end;
    bce = b_read_length - b_clear_begin;
    ok  = !((ab >= ae) || (bb >= be)) &&
          !((ace <= ab) || (ae <= acb) || (bce <= bb) || (be <= bcb));
    alen = ae - ab;
    blen = be - bb;
    anb  = (acb < ab) ? '0 : acb - ab;
    bnb  = (bcb < bb) ? '0 : bcb - bb;
    ane  = (ace > ae) ? '0 : ae - ace;
    bne  = (bce > be) ? '0 : be - bce;
  end

  assign rec = {ok, ab, ae, bb, be, acb, ace, bcb, bce, alen, blen, anb, bnb, ane, bne};

endmodule

[rtl/fota_queue.sv]
// small record queue between front and back
module fota_queue #(
  parameter int RW = 337
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [RW-1:0]     wdata,
  input  logic              pop,
  output logic [RW-1:0]     rdata,
  output fota_pkg::q_stat_t stat
);

  logic [RW-1:0]                 mem [fota_pkg::QDEPTH];
  logic [fota_pkg::QPTR_W-1:0]   wptr, rptr;
  logic [fota_pkg::QPTR_W:0]     count, count_next;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  assign rdata      = mem[rptr];
  assign stat.full  = (count == (fota_pkg::QPTR_W+1)'(fota_pkg::QDEPTH));
  assign stat.empty = (count == '0);

endmodule

[rtl/fota_back.sv]
// back end: fraction compare, scaled products, pipelined dividers, rounding
module fota_back #(
  parameter int W  = 24,
  parameter int RW = 1 + 14 * W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [RW-1:0] rec,
  output logic          o_valid,
  output logic          o_ok,
  output logic [W-1:0]  o_ab,
  output logic [W-1:0]  o_ae,
  output logic [W-1:0]  o_bb,
  output logic [W-1:0]  o_be,
  output logic [W-1:0]  o_acb,
  output logic [W-1:0]  o_ace,
  output logic [W-1:0]  o_bcb,
  output logic [W-1:0]  o_bce
);

  localparam int SW = 1 + 8 * W;
  localparam int W2 = 2 * W;
  localparam int L  = fota_pkg::LANES;

  logic [SW-1:0] q_side;
  logic [W-1:0]  q_alen, q_blen, q_anb, q_bnb, q_ane, q_bne;

  assign {q_side, q_alen, q_blen, q_anb, q_bnb, q_ane, q_bne} = rec;

  // stage 1: cross products
  logic          s1_v;
  logic [SW-1:0] s1_side;
  logic [W-1:0]  s1_alen, s1_blen, s1_anb, s1_bnb, s1_ane, s1_bne;
  logic [W2-1:0] s1_pb_b, s1_pb_a, s1_pe_b, s1_pe_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side <= q_side;
      s1_alen <= q_alen;
      s1_blen <= q_blen;
      s1_anb  <= q_anb;
      s1_bnb  <= q_bnb;
      s1_ane  <= q_ane;
      s1_bne  <= q_bne;
      s1_pb_b <= q_bnb * q_alen;
      s1_pb_a <= q_anb * q_blen;
      s1_pe_b <= q_bne * q_alen;
      s1_pe_a <= q_ane * q_blen;
    end
  end

  // stage 2: pick the larger fraction per end, ties to a
  logic          s2_v;
  logic [SW-1:0] s2_side;
  logic [W-1:0]  s2_alen, s2_blen, s2_nb, s2_db, s2_ne, s2_de;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_side <= s1_side;
      s2_alen <= s1_alen;
      s2_blen <= s1_blen;
      if (s1_pb_b > s1_pb_a) begin
        s2_nb <= s1_bnb;
        s2_db <= s1_blen;
      end else begin
        s2_nb <= s1_anb;
        s2_db <= s1_alen;
      end
      if (s1_pe_b > s1_pe_a) begin
        s2_ne <= s1_bne;
        s2_de <= s1_blen;
      end else begin
        s2_ne <= s1_ane;
        s2_de <= s1_alen;
      end
    end
  end

  // divider pipeline, index 0 holds the scaled products
  logic          dv_v    [W+1];
  logic [SW-1:0] dv_side [W+1];
  logic [W-1:0]  dv_r    [W+1][L];
  logic [W-1:0]  dv_l    [W+1][L];
  logic [W-1:0]  dv_d    [W+1][L];

  logic [W2-1:0] prod [L];
  logic [W-1:0]  pden [L];

  always_comb begin
    prod[0] = s2_nb * s2_alen;
    prod[1] = s2_nb * s2_blen;
    prod[2] = s2_ne * s2_alen;
    prod[3] = s2_ne * s2_blen;
    pden[0] = s2_db;
    pden[1] = s2_db;
    pden[2] = s2_de;
    pden[3] = s2_de;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_side[0] <= s2_side;
      for (int k = 0; k < L; k++) begin
        dv_r[0][k] <= prod[k][W2-1:W];
        dv_l[0][k] <= prod[k][W-1:0];
        dv_d[0][k] <= pden[k];
      end
    end
  end

  // one quotient bit per stage, shifted into the low word
  for (genvar i = 0; i < W; i++) begin : g_div
    logic [W:0]   trial [L];
    logic         ge    [L];

    always_comb begin
      for (int k = 0; k < L; k++) begin
        trial[k] = {dv_r[i][k], dv_l[i][k][W-1]};
        ge[k]    = (trial[k] >= {1'b0, dv_d[i][k]});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[i+1] <= 1'b0;
      end else if (en) begin
        dv_v[i+1] <= dv_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_side[i+1] <= dv_side[i];
        for (int k = 0; k < L; k++) begin
          dv_r[i+1][k] <= ge[k] ? W'(trial[k] - {1'b0, dv_d[i][k]}) : trial[k][W-1:0];
          dv_l[i+1][k] <= {dv_l[i][k][W-2:0], ge[k]};
          dv_d[i+1][k] <= dv_d[i][k];
        end
      end
    end
  end

  // final stage: round half up and apply
  logic [W-1:0] rnd [L];
  logic         f_ok;
  logic [W-1:0] f_ab, f_ae, f_bb, f_be, f_acb, f_ace, f_bcb, f_bce;

  assign {f_ok, f_ab, f_ae, f_bb, f_be, f_acb, f_ace, f_bcb, f_bce} = dv_side[W];

  always_comb begin
    for (int k = 0; k < L; k++) begin
      rnd[k] = dv_l[W][k] + W'({dv_r[W][k], 1'b0} >= {1'b0, dv_d[W][k]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= dv_v[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_ok  <= f_ok;
      o_ab  <= f_ok ? f_ab + rnd[0] : f_ab;
      o_bb  <= f_ok ? f_bb + rnd[1] : f_bb;
      o_ae  <= f_ok ? f_ae - rnd[2] : f_ae;
      o_be  <= f_ok ? f_be - rnd[3] : f_be;
      o_acb <= f_acb;
      o_ace <= f_ace;
      o_bcb <= f_bcb;
      o_bce <= f_bce;
    end
  end

endmodule

[rtl/flipped_overlap_trim_adjust.sv]
// top level of the flipped overlap trim adjust block
//
//   channel | dir | carries
//   --------+-----+-------------------------------------------------------
//   req     | in  | overlap on a and raw b, both clear ranges, b length
//   rsp     | out | accepted flag, adjusted overlap, a clear, mirrored b clear
//
// one item per cycle sustained while rsp is taken; results pass the queue, the
// product and compare stages and the one-bit-per-stage restoring dividers
// rst is synchronous and empties the queue and every pipeline valid bit
// the back pipeline advances whenever the rsp register is empty or taken;
// while it stalls, the four-entry queue keeps taking items until full
module flipped_overlap_trim_adjust #(
  parameter int COORD_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst,
  fota_in_if.sink     req,
  fota_out_if.source  rsp
);

  localparam int W  = COORD_WIDTH;
  localparam int RW = 1 + 14 * W;

  logic [RW-1:0]     front_rec;
  logic [RW-1:0]     q_rec;
  fota_pkg::q_stat_t q_stat;
  logic              push, pop, en;

  // classification and mirroring, no storage
  fota_front #(.W(W), .RW(RW)) u_front (
    .a_overlap_begin (req.a_overlap_begin),
    .a_overlap_end   (req.a_overlap_end),
    .b_overlap_first (req.b_overlap_first),
    .b_overlap_last  (req.b_overlap_last),
    .a_clear_begin   (req.a_clear_begin),
    .a_clear_end     (req.a_clear_end),
    .b_clear_begin   (req.b_clear_begin),
    .b_clear_end     (req.b_clear_end),
    .b_read_length   (req.b_read_length),
    .rec             (front_rec)
  );

  // accept whenever the queue has room
  assign req.ready = !q_stat.full;
  assign push      = req.valid && !q_stat.full;

  // back moves when its output register is free or being taken
  assign en  = !rsp.valid || rsp.ready;
  assign pop = en && !q_stat.empty;

  fota_queue #(.RW(RW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_rec),
    .pop   (pop),
    .rdata (q_rec),
    .stat  (q_stat)
  );

  fota_back #(.W(W), .RW(RW)) u_back (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (!q_stat.empty),
    .rec      (q_rec),
    .o_valid  (rsp.valid),
    .o_ok     (rsp.accepted),
    .o_ab     (rsp.a_adj_begin),
    .o_ae     (rsp.a_adj_end),
    .o_bb     (rsp.b_adj_begin),
    .o_be     (rsp.b_adj_end),
    .o_acb    (rsp.a_clr_begin_out),
    .o_ace    (rsp.a_clr_end_out),
    .o_bcb    (rsp.b_clr_begin_flip),
    .o_bce    (rsp.b_clr_end_flip)
  );

endmodule

[rtl/fota_checker.sv]
// port-level checks for the flipped overlap trim adjust block
module fota_checker (
  input logic clk,
  input logic rst,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic rsp_accepted
);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("rsp valid right after reset");

  // the queue can only fill up while the output is stalled
  a_full_needs_stall: assert property (@(posedge clk) disable iff (rst)
    $fell(req_ready) |-> $past(rsp_valid && !rsp_ready))
    else $error("req ready dropped without output stall");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_accepted))
    else $error("stalled rsp item changed");

endmodule

bind flipped_overlap_trim_adjust fota_checker u_fota_checker (
  .clk          (clk),
  .rst          (rst),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_accepted (rsp.accepted)
);

[sim/fota_trim_checker.sv]
// checker module: predicts adjusted overlaps from accepted records and compares results
module fota_trim_checker #(
  parameter int W = 24
) (
  input  logic        clk,
  input  logic        rst,
  fota_in_if.sink     req_mon,
  fota_out_if.sink    rsp_mon,
  output int          fail_count,
  output int          pending_count,
  output int          result_count,
  output int          accepted_count
);

  typedef struct packed {
    logic         accepted;
    logic [W-1:0] a_adj_begin;
    logic [W-1:0] a_adj_end;
    logic [W-1:0] b_adj_begin;
    logic [W-1:0] b_adj_end;
    logic [W-1:0] a_clr_begin;
    logic [W-1:0] a_clr_end;
    logic [W-1:0] b_clr_begin;
    logic [W-1:0] b_clr_end;
  } trim_result_t;

  trim_result_t pending_trims[$];

  // round num * len / den half up
  function automatic logic [127:0] round_share(logic [127:0] num, logic [127:0] den,
                                               logic [127:0] len);
    logic [127:0] prod, q, r;
    prod = num * len;
    q = prod / den;
    r = prod % den;
    if (2 * r >= den) q = q + 1;
    return q;
  endfunction

  function automatic trim_result_t predict_trim(
      logic [W-1:0] aob, logic [W-1:0] aoe, logic [W-1:0] bof, logic [W-1:0] bol,
      logic [W-1:0] acb, logic [W-1:0] ace, logic [W-1:0] bcb_raw,
      logic [W-1:0] bce_raw, logic [W-1:0] blen_rd);
    trim_result_t res;
    logic [W-1:0] ab, ae, bb, be, bcb, bce;
    logic [127:0] alen, blen, anb, bnb, ane, bne, nb, db, ne, de, abx, aex, bbx, bex;
    logic ok;
    ab = aob;
    ae = aoe;
    bb = blen_rd - bof;
    be = blen_rd - bol;
    bcb = blen_rd - bce_raw;
    bce = blen_rd - bcb_raw;
    ok = 1'b1;
    if (ab >= ae || bb >= be) ok = 1'b0;
    else if (ace <= ab || ae <= acb || bce <= bb || be <= bcb) ok = 1'b0;
    abx = ab; aex = ae; bbx = bb; bex = be;
    if (ok) begin
      alen = ae - ab;
      blen = be - bb;
      anb = (acb < ab) ? 0 : acb - ab;
      bnb = (bcb < bb) ? 0 : bcb - bb;
      ane = (ace > ae) ? 0 : ae - ace;
      bne = (bce > be) ? 0 : be - bce;
      if (bnb * alen > anb * blen) begin
        nb = bnb; db = blen;
      end else begin
        nb = anb; db = alen;
      end
      if (bne * alen > ane * blen) begin
        ne = bne; de = blen;
      end else begin
        ne = ane; de = alen;
      end
      abx = abx + round_share(nb, db, alen);
      bbx = bbx + round_share(nb, db, blen);
      aex = aex - round_share(ne, de, alen);
      bex = bex - round_share(ne, de, blen);
    end
    res.accepted = ok;
    res.a_adj_begin = abx[W-1:0];
    res.a_adj_end = aex[W-1:0];
    res.b_adj_begin = bbx[W-1:0];
    res.b_adj_end = bex[W-1:0];
    res.a_clr_begin = acb;
    res.a_clr_end = ace;
    res.b_clr_begin = bcb;
    res.b_clr_end = bce;
    return res;
  endfunction

  assign pending_count = pending_trims.size();

  initial begin
    fail_count = 0;
    result_count = 0;
    accepted_count = 0;
  end

  always @(posedge clk) begin
    trim_result_t want, got;
    if (!rst && req_mon.valid && req_mon.ready)
      pending_trims.push_back(predict_trim(req_mon.a_overlap_begin, req_mon.a_overlap_end,
          req_mon.b_overlap_first, req_mon.b_overlap_last, req_mon.a_clear_begin,
          req_mon.a_clear_end, req_mon.b_clear_begin, req_mon.b_clear_end,
          req_mon.b_read_length));
    if (!rst && rsp_mon.valid && rsp_mon.ready) begin
      got = {rsp_mon.accepted, rsp_mon.a_adj_begin, rsp_mon.a_adj_end, rsp_mon.b_adj_begin,
             rsp_mon.b_adj_end, rsp_mon.a_clr_begin_out, rsp_mon.a_clr_end_out,
             rsp_mon.b_clr_begin_flip, rsp_mon.b_clr_end_flip};
      result_count++;
      if (got.accepted) accepted_count++;
      if (pending_trims.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result item %p", got);
      end else begin
        want = pending_trims.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

endmodule

[sim/testbench.sv]
// top of the testbench: record stimulus, random idling on both sides, verdict
module testbench;

  localparam int W = 24;
  localparam logic [W-1:0] MAXC = {W{1'b1}};
  localparam int RANDOM_ITEMS = 550;
  localparam int DRAIN_CYCLES = W + 20;

  logic clk;
  logic rst;
  int   fail_count, pending_count, result_count, accepted_count;

  fota_in_if  #(.W(W)) req ();
  fota_out_if #(.W(W)) rsp ();

  flipped_overlap_trim_adjust #(.COORD_WIDTH(W)) dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  fota_trim_checker #(.W(W)) checker_i (
    .clk            (clk),
    .rst            (rst),
    .req_mon        (req.sink),
    .rsp_mon        (rsp.sink),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .result_count   (result_count),
    .accepted_count (accepted_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // half the time no gap at all, else mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // bursts with no stall at all alternate with stretches of random stalling
  bit rsp_burst;
  int rsp_hold;
  initial begin
    rsp.ready = 1'b0;
    rsp_burst = 1'b0;
    rsp_hold = 0;
    forever begin
      @(negedge clk);
      if (rsp_hold > 0) begin
        rsp_hold--;
        rsp.ready <= 1'b0;
      end else if (rsp_burst || $urandom_range(0, 3) != 0) begin
        rsp.ready <= 1'b1;
        if (!rsp_burst && $urandom_range(0, 5) == 0) rsp_hold = idle_gap();
      end else begin
        rsp.ready <= 1'b0;
      end
      if ($urandom_range(0, 63) == 0) rsp_burst = !rsp_burst;
    end
  end

  // hand one record to the block; valid stays high across back-to-back items
  task automatic send_record(logic [W-1:0] aob, logic [W-1:0] aoe, logic [W-1:0] bof,
                             logic [W-1:0] bol, logic [W-1:0] acb, logic [W-1:0] ace,
                             logic [W-1:0] bcb, logic [W-1:0] bce, logic [W-1:0] blen,
                             bit gaps);
    int gap;
    gap = gaps ? idle_gap() : 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.a_overlap_begin <= aob;
    req.a_overlap_end <= aoe;
    req.b_overlap_first <= bof;
    req.b_overlap_last <= bol;
    req.a_clear_begin <= acb;
    req.a_clear_end <= ace;
    req.b_clear_begin <= bcb;
    req.b_clear_end <= bce;
    req.b_read_length <= blen;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [W-1:0] rand_coord();
    return W'($urandom());
  endfunction

  // well-formed flipped overlap with clear ranges that may cut either end by random amounts
  task automatic send_good_overlap(logic [W-1:0] span_max, bit gaps);
    logic [W-1:0] blen, aob, aoe, bb, be, acb, ace, bcb_f, bce_f, alen_o, blen_o;
    blen_o = W'($urandom_range(1, span_max));
    alen_o = ($urandom_range(0, 3) == 0) ? blen_o : W'($urandom_range(1, span_max));
    blen = W'($urandom_range(blen_o, MAXC));
    aob = W'($urandom_range(0, MAXC - alen_o));
    aoe = aob + alen_o;
    bb = W'($urandom_range(0, blen - blen_o));
    be = bb + blen_o;
    // clear ranges may lie inside, straddle or enclose the overlap
    acb = W'(($urandom_range(0, 2) == 0) ? $urandom_range(0, aob)
                                         : $urandom_range(aob, aoe - 1));
    ace = W'(($urandom_range(0, 2) == 0) ? $urandom_range(aoe, MAXC)
                                         : $urandom_range(acb + 1 > aob + 1 ? acb + 1 : aob + 1,
                                                          aoe));
    bcb_f = W'(($urandom_range(0, 2) == 0) ? $urandom_range(0, bb)
                                           : $urandom_range(bb, be - 1));
    bce_f = W'(($urandom_range(0, 2) == 0) ? $urandom_range(be, blen)
                                           : $urandom_range(bcb_f + 1 > bb + 1 ? bcb_f + 1
                                                                               : bb + 1,
                                                            be));
    send_record(aob, aoe, blen - bb, blen - be, acb, ace, blen - bce_f, blen - bcb_f, blen,
                gaps);
  endtask

  initial begin
    int kind;
    req.valid = 1'b0;
    req.a_overlap_begin = '0;
    req.a_overlap_end = '0;
    req.b_overlap_first = '0;
    req.b_overlap_last = '0;
    req.a_clear_begin = '0;
    req.a_clear_end = '0;
    req.b_clear_begin = '0;
    req.b_clear_end = '0;
    req.b_read_length = '0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: all zeros and all ones
    send_record('0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0);
    send_record(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, 1'b0);
    // clean overlap fully inside both clear ranges, nothing trimmed
    send_record(100, 200, 900, 800, 0, 1000, 0, 1000, 1000, 1'b0);
    // a clear range cuts both ends, but the mirrored b clear range misses the overlap: rejected
    send_record(100, 200, 900, 800, 130, 190, 150, 180, 1000, 1'b0);
    send_record(100, 200, 900, 810, 110, 150, 100, 800, 1000, 1'b1);
    // equal fractions on both reads
    send_record(0, 100, 100, 0, 25, 75, 25, 75, 100, 1'b0);
    // rounding below and then exactly at one half
    send_record(0, 3, 4, 0, 1, 3, 0, 4, 4, 1'b0);
    send_record(0, 2, 3, 0, 1, 2, 0, 3, 3, 1'b1);
    // after mirroring both clear ranges cut the begin, the larger cut from a wins
    send_record(0, 10, 10, 0, 6, 10, 0, 6, 10, 1'b0);
    // empty and then reversed overlap on a, then reversed overlap on mirrored b
    send_record(50, 50, 90, 10, 0, 100, 0, 100, 100, 1'b0);
    send_record(60, 40, 90, 10, 0, 100, 0, 100, 100, 1'b0);
    send_record(10, 90, 10, 90, 0, 100, 0, 100, 100, 1'b0);
    // clear range missed on each side in turn
    send_record(10, 20, 90, 80, 20, 100, 0, 100, 100, 1'b0);
    send_record(10, 20, 90, 80, 0, 10, 0, 100, 100, 1'b1);
    send_record(10, 20, 90, 80, 0, 100, 90, 100, 100, 1'b0);
    send_record(10, 20, 90, 80, 0, 100, 0, 10, 100, 1'b0);
    // mirror wrap: b coordinates beyond the read length, then a full-width span
    send_record(10, 20, 200, 150, 0, 100, 120, 300, 100, 1'b0);
    send_record(0, MAXC, MAXC, 0, 0, MAXC, 0, MAXC, MAXC, 1'b1);
    // largest spans with full-width products
    send_record(0, MAXC, MAXC, 0, 1, MAXC - 1, 3, MAXC - 7, MAXC, 1'b0);
    send_record(1, MAXC, MAXC, 1, MAXC / 3, MAXC, 0, MAXC / 2, MAXC, 1'b0);

    // random: mostly well-formed overlaps, some raw noise
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) send_good_overlap(W'(($urandom_range(0, 1) == 0) ? 64 : 4096), i % 7 != 0);
      else if (kind < 75) send_good_overlap(MAXC, i % 5 != 0);
      else send_record(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord(), rand_coord(), rand_coord(), 1'b1);
    end
    req.valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d directed and %0d random records, %0d results checked, %0d accepted",
             20, RANDOM_ITEMS, result_count, accepted_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog far beyond the slowest correct run
  initial begin
    #4000000;
    $display("timeout with %0d items outstanding", pending_count);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
